@@ design/emsm_pkg.sv @@
`default_nettype none

package emsm_pkg;

  typedef enum logic [1:0] {
    CMD_FALL   = 2'd0,
    CMD_RISE   = 2'd1,
    CMD_OVF    = 2'd2,
    CMD_SAMPLE = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [1:0]  channel;
    logic        phase_b;
    logic [15:0] timer_now;
    logic [15:0] capture_period;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         out_channel;
    logic signed [31:0] rpm;
    logic               saw_edge;
  } out_word_t;

  // one history entry of a channel's ring
  typedef struct packed {
    logic signed [31:0] msum;
    logic [31:0]        fabs;
    logic [31:0]        labs;
    logic               edge_mark;
    logic [1:0]         dir;
    logic [15:0]        period;
  } hist_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_ADDR,
    ST_READ_DATA,
    ST_SELECT,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_EDGES_PER_REV   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RPM_SCALE       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_INV   = 8'd3;

  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b11;

  localparam logic [31:0] K_FAST_LIMIT = 32'd6;
  localparam int          K_MID        = 3;

  localparam logic [5:0] MUL_LAST = 6'd31;
  localparam logic [5:0] DIV_LAST = 6'd63;

endpackage

`default_nettype wire

@@ design/encoder_mt_speed_meter.sv @@
// Edge and overflow words take effect in the accepting cycle and give no result. A sample
// word reads each older history entry to be averaged (an address and a data state each),
// then a select state, a bit-serial multiply, a restoring divide and a done state; multiply
// and divide are skipped when the rule yields zero. A sample word is taken only when idle
// with no result waiting; edge words one per cycle while idle, also while a result waits.
// Synchronous active-high reset clears config to defaults and all channel state;
// the history ring is not cleared and only entries written since reset are read.
`default_nettype none

module encoder_mt_speed_meter #(
  parameter int CHANNELS      = 4,
  parameter int HISTORY_DEPTH = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire emsm_pkg::in_word_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output emsm_pkg::out_word_t                   out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [emsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                      cfg_data
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RW    = $clog2(HISTORY_DEPTH);
  localparam int FW    = $clog2(HISTORY_DEPTH + 1);
  localparam int AW    = $clog2(CHANNELS * HISTORY_DEPTH);
  localparam int SUM_W = 33 + $clog2(HISTORY_DEPTH);
  localparam logic [4:0]    CH_CNT   = 5'(CHANNELS);
  localparam logic [RW-1:0] RW_LAST  = RW'(HISTORY_DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(HISTORY_DEPTH);

  // configuration
  logic [19:0] edges_per_rev;
  logic [31:0] rpm_scale;
  logic [2:0]  active_channels;
  logic [3:0]  direction_invert;

  // per-channel state
  logic signed [31:0] window_count     [CHANNELS];
  logic [15:0]        first_edge_time  [CHANNELS];
  logic [15:0]        last_edge_time   [CHANNELS];
  logic [1:0]         last_direction   [CHANNELS];
  logic               edge_seen        [CHANNELS];
  logic [15:0]        held_period      [CHANNELS];
  logic [15:0]        overflow_count   [CHANNELS];
  logic [31:0]        last_abs_time    [CHANNELS];
  logic [RW-1:0]      ring_write_index [CHANNELS];
  logic [FW-1:0]      ring_fill        [CHANNELS];

  emsm_pkg::hist_t ring [CHANNELS * HISTORY_DEPTH];
  emsm_pkg::hist_t rd_q;

  emsm_pkg::state_t state, state_next;

  // sample snapshot and window accumulation
  logic [CH_W-1:0]    s_ch_idx;
  logic [1:0]         s_ch;
  logic [31:0]        s_now_abs;
  logic signed [31:0] s_m;
  logic [31:0]        s_mag;
  logic               s_had;
  logic [15:0]        s_period;
  logic [1:0]         s_ldir;
  logic [15:0]        s_first;
  logic [15:0]        s_last;
  logic [31:0]        s_prev_abs;
  logic               s_avg;
  logic [SUM_W-1:0]   s_sum;
  logic               s_any;
  logic [31:0]        s_wl;
  logic [31:0]        s_wf;
  logic [1:0]         s_wdir;
  logic [15:0]        s_wper;
  logic [RW-1:0]      rd_ptr;
  logic [FW-1:0]      rd_left;

  // speed unit
  logic        op_neg;
  logic [63:0] mc_a;
  logic [31:0] mp_a;
  logic [63:0] acc_n;
  logic [51:0] mc_b;
  logic [19:0] mp_b;
  logic [51:0] acc_d;
  logic [51:0] rem;
  logic [5:0]  cnt;

  // input side decode
  emsm_pkg::cmd_t  cmd;
  logic [CH_W-1:0] ch_idx;
  logic [4:0]      act;
  logic            live;
  logic            accept;
  logic            is_sample;
  logic            rising;
  logic            pos;
  logic signed [31:0] cur_m;
  logic [31:0]     cur_mag;
  logic [RW-1:0]   cur_w;
  logic [FW-1:0]   fill_next;
  logic [FW-1:0]   k_raw;
  logic [FW-1:0]   k_eff;
  logic [31:0]     now_abs;
  emsm_pkg::hist_t entry;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [RW-1:0]   ptr_dec;
  logic [AW-1:0]   mem_raddr;

  // select stage
  logic [31:0] sum_sat;
  logic        avg_speed;
  logic        avg_decay;
  logic [1:0]  dk_dir;
  logic [31:0] dk_from;
  logic [15:0] dk_per;
  logic [31:0] dk_since;
  logic [31:0] dk_p;
  logic [31:0] dk_ticks;
  logic [15:0] d16;
  logic [31:0] dt_avg;
  logic        sel_zero;
  logic        sel_neg;
  logic [31:0] sel_mag;
  logic [31:0] sel_ticks;

  logic [52:0] rem_sh;
  logic        q_bit;
  logic [31:0] sat_rpm;

  assign cfg_ready = 1'b1;

  always_comb begin
    cmd       = in_data.command;
    ch_idx    = CH_W'(in_data.channel);
    act       = ({2'b00, active_channels} < CH_CNT) ? {2'b00, active_channels} : CH_CNT;
    live      = {3'b000, in_data.channel} < act;
    is_sample = (in_data.command == emsm_pkg::CMD_SAMPLE);
    in_ready  = (state == emsm_pkg::ST_IDLE) && (!out_valid || !is_sample);
    accept    = in_valid && in_ready;
    rising    = (cmd == emsm_pkg::CMD_RISE);
    pos       = (in_data.phase_b != rising) ^ direction_invert[in_data.channel];

    cur_m     = window_count[ch_idx];
    cur_mag   = cur_m[31] ? (~cur_m + 32'd1) : cur_m;
    cur_w     = ring_write_index[ch_idx];
    fill_next = (ring_fill[ch_idx] < FILL_MAX) ? ring_fill[ch_idx] + FW'(1) : ring_fill[ch_idx];
    if (cur_mag >= emsm_pkg::K_FAST_LIMIT) begin
      k_raw = FW'(1);
    end else if (cur_mag >= 32'd2) begin
      k_raw = FW'(emsm_pkg::K_MID);
    end else begin
      k_raw = FILL_MAX;
    end
    k_eff   = (k_raw > fill_next) ? fill_next : k_raw;
    now_abs = {overflow_count[ch_idx], in_data.timer_now};

    entry.msum      = cur_m;
    entry.fabs      = edge_seen[ch_idx] ? {overflow_count[ch_idx], first_edge_time[ch_idx]}
                                        : 32'd0;
    entry.labs      = edge_seen[ch_idx] ? {overflow_count[ch_idx], last_edge_time[ch_idx]}
                                        : 32'd0;
    entry.edge_mark = edge_seen[ch_idx];
    entry.dir       = last_direction[ch_idx];
    entry.period    = held_period[ch_idx];

    mem_we    = accept && is_sample && live;
    mem_waddr = AW'(int'(ch_idx) * HISTORY_DEPTH + int'(cur_w));
    ptr_dec   = (rd_ptr == '0) ? RW_LAST : rd_ptr - RW'(1);
    mem_raddr = AW'(int'(s_ch_idx) * HISTORY_DEPTH + int'(ptr_dec));
  end

  // select which speed rule to run
  always_comb begin
    if (&s_sum[SUM_W-1:31] || ~|s_sum[SUM_W-1:31]) begin
      sum_sat = s_sum[31:0];
    end else begin
      sum_sat = s_sum[SUM_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    avg_speed = s_avg && s_any && (sum_sat != 32'd0);
    avg_decay = s_avg && !avg_speed && (sum_sat == 32'd0) && (s_wdir != emsm_pkg::DIR_NONE);

    dk_dir   = avg_decay ? s_wdir : s_ldir;
    dk_from  = avg_decay ? s_wl : s_prev_abs;
    dk_per   = avg_decay ? s_wper : s_period;
    dk_since = s_now_abs - dk_from;
    dk_p     = (dk_per == 16'd0) ? 32'd1 : {16'd0, dk_per};
    dk_ticks = (dk_since > dk_p) ? dk_since : dk_p;

    d16    = s_last - s_first;
    dt_avg = ((s_wl - s_wf) == 32'd0) ? 32'd1 : s_wl - s_wf;

    sel_zero  = 1'b0;
    sel_neg   = 1'b0;
    sel_mag   = 32'd1;
    sel_ticks = dk_ticks;
    if (avg_speed) begin
      sel_neg   = sum_sat[31];
      sel_mag   = sum_sat[31] ? (~sum_sat + 32'd1) : sum_sat;
      sel_ticks = dt_avg;
    end else if (avg_decay) begin
      sel_neg = dk_dir[1];
    end else if (s_mag >= 32'd2) begin
      sel_neg   = s_m[31];
      sel_mag   = s_mag;
      sel_ticks = (d16 == 16'd0) ? 32'h0001_0000 : {16'd0, d16};
    end else if (s_mag == 32'd1) begin
      sel_neg = s_m[31];
      if (s_period == 16'd0) begin
        sel_ticks = (dk_since == 32'd0) ? 32'd1 : dk_since;
      end else begin
        sel_ticks = {16'd0, s_period};
      end
    end else if (s_ldir != emsm_pkg::DIR_NONE) begin
      sel_neg = dk_dir[1];
    end else begin
      sel_zero = 1'b1;
    end
    if (edges_per_rev == 20'd0) begin
      sel_zero = 1'b1;
    end

    rem_sh = {rem, acc_n[63]};
    q_bit  = (rem_sh >= {1'b0, acc_d});

    if (op_neg) begin
      sat_rpm = (acc_n > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (~acc_n[31:0] + 32'd1);
    end else begin
      sat_rpm = (acc_n > 64'h0000_0000_7fff_ffff) ? 32'h7fff_ffff : acc_n[31:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      emsm_pkg::ST_IDLE: begin
        if (mem_we) begin
          state_next = (k_eff >= FW'(2)) ? emsm_pkg::ST_READ_ADDR : emsm_pkg::ST_SELECT;
        end
      end
      emsm_pkg::ST_READ_ADDR: state_next = emsm_pkg::ST_READ_DATA;
      emsm_pkg::ST_READ_DATA: begin
        state_next = (rd_left == FW'(1)) ? emsm_pkg::ST_SELECT : emsm_pkg::ST_READ_ADDR;
      end
      emsm_pkg::ST_SELECT: state_next = sel_zero ? emsm_pkg::ST_DONE : emsm_pkg::ST_MUL;
      emsm_pkg::ST_MUL: begin
        if (cnt == emsm_pkg::MUL_LAST) begin
          state_next = emsm_pkg::ST_DIV;
        end
      end
      emsm_pkg::ST_DIV: begin
        if (cnt == emsm_pkg::DIV_LAST) begin
          state_next = emsm_pkg::ST_DONE;
        end
      end
      emsm_pkg::ST_DONE: state_next = emsm_pkg::ST_IDLE;
      default: state_next = emsm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= emsm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // history ring
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[mem_waddr] <= entry;
    end
    if (state == emsm_pkg::ST_READ_ADDR) begin
      rd_q <= ring[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edges_per_rev    <= 20'd1;
      rpm_scale        <= 32'd1;
      active_channels  <= 3'd4;
      direction_invert <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        emsm_pkg::REG_EDGES_PER_REV:   edges_per_rev    <= cfg_data[19:0];
        emsm_pkg::REG_RPM_SCALE:       rpm_scale        <= cfg_data;
        emsm_pkg::REG_ACTIVE_CHANNELS: active_channels  <= cfg_data[2:0];
        emsm_pkg::REG_DIRECTION_INV:   direction_invert <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // channel state: edges, overflows, sample clear
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        window_count[c]     <= '0;
        first_edge_time[c]  <= '0;
        last_edge_time[c]   <= '0;
        last_direction[c]   <= emsm_pkg::DIR_NONE;
        edge_seen[c]        <= 1'b0;
        held_period[c]      <= '0;
        overflow_count[c]   <= '0;
        last_abs_time[c]    <= '0;
        ring_write_index[c] <= '0;
        ring_fill[c]        <= '0;
      end
    end else if (accept && live) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (CH_W'(c) == ch_idx) begin
          case (cmd)
            emsm_pkg::CMD_FALL, emsm_pkg::CMD_RISE: begin
              window_count[c] <= pos ? cur_m + 32'sd1 : cur_m - 32'sd1;
              if (!edge_seen[c]) begin
                first_edge_time[c] <= in_data.timer_now;
              end
              edge_seen[c]      <= 1'b1;
              last_edge_time[c] <= in_data.timer_now;
              last_abs_time[c]  <= now_abs;
              last_direction[c] <= pos ? emsm_pkg::DIR_POS : emsm_pkg::DIR_NEG;
              if (rising) begin
                held_period[c] <= in_data.capture_period;
              end
            end
            emsm_pkg::CMD_OVF: overflow_count[c] <= overflow_count[c] + 16'd1;
            emsm_pkg::CMD_SAMPLE: begin
              window_count[c]     <= '0;
              edge_seen[c]        <= 1'b0;
              ring_write_index[c] <= (cur_w == RW_LAST) ? '0 : cur_w + RW'(1);
              ring_fill[c]        <= fill_next;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // sample sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      emsm_pkg::ST_IDLE: begin
        if (mem_we) begin
          s_ch_idx   <= ch_idx;
          s_ch       <= in_data.channel;
          s_now_abs  <= now_abs;
          s_m        <= cur_m;
          s_mag      <= cur_mag;
          s_had      <= entry.edge_mark;
          s_period   <= entry.period;
          s_ldir     <= entry.dir;
          s_first    <= first_edge_time[ch_idx];
          s_last     <= last_edge_time[ch_idx];
          s_prev_abs <= last_abs_time[ch_idx];
          s_avg      <= (k_eff >= FW'(2));
          s_sum      <= {{(SUM_W-32){cur_m[31]}}, cur_m};
          s_any      <= entry.edge_mark;
          s_wl       <= entry.labs;
          s_wf       <= entry.fabs;
          s_wdir     <= entry.edge_mark ? entry.dir : emsm_pkg::DIR_NONE;
          s_wper     <= entry.edge_mark ? entry.period : 16'd0;
          rd_ptr     <= cur_w;
          rd_left    <= k_eff - FW'(1);
        end
      end
      emsm_pkg::ST_READ_ADDR: rd_ptr <= ptr_dec;
      emsm_pkg::ST_READ_DATA: begin
        s_sum   <= s_sum + {{(SUM_W-32){rd_q.msum[31]}}, rd_q.msum};
        rd_left <= rd_left - FW'(1);
        if (rd_q.edge_mark) begin
          // newest entry with an edge sets the window end, oldest sets its start
          if (!s_any) begin
            s_wl   <= rd_q.labs;
            s_wdir <= rd_q.dir;
            s_wper <= rd_q.period;
            s_any  <= 1'b1;
          end
          s_wf <= rd_q.fabs;
        end
      end
      emsm_pkg::ST_SELECT: begin
        op_neg <= sel_neg;
        mc_a   <= {32'd0, sel_mag};
        mp_a   <= rpm_scale;
        mc_b   <= {20'd0, sel_ticks};
        mp_b   <= edges_per_rev;
        acc_n  <= '0;
        acc_d  <= '0;
        cnt    <= '0;
      end
      emsm_pkg::ST_MUL: begin
        if (mp_a[0]) begin
          acc_n <= acc_n + mc_a;
        end
        if (mp_b[0]) begin
          acc_d <= acc_d + mc_b;
        end
        mc_a <= {mc_a[62:0], 1'b0};
        mp_a <= {1'b0, mp_a[31:1]};
        mc_b <= {mc_b[50:0], 1'b0};
        mp_b <= {1'b0, mp_b[19:1]};
        rem  <= '0;
        cnt  <= (cnt == emsm_pkg::MUL_LAST) ? '0 : cnt + 6'd1;
      end
      emsm_pkg::ST_DIV: begin
        // shift quotient bits in behind the numerator
        acc_n <= {acc_n[62:0], q_bit};
        rem   <= q_bit ? 52'(rem_sh - {1'b0, acc_d}) : rem_sh[51:0];
        cnt   <= cnt + 6'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == emsm_pkg::ST_DONE || (accept && is_sample && !live)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == emsm_pkg::ST_DONE) begin
      out_data.out_channel <= s_ch;
      out_data.rpm         <= sat_rpm;
      out_data.saw_edge    <= s_had;
    end else if (accept && is_sample && !live) begin
      out_data.out_channel <= in_data.channel;
      out_data.rpm         <= '0;
      out_data.saw_edge    <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ design/emsm_checker.sv @@
`default_nettype none

module emsm_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire emsm_pkg::in_word_t             in_data,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire emsm_pkg::out_word_t            out_data,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready
);

  // a pending result word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped or changed while stalled");

  // no sample word taken while a result still waits
  a_sample_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.command == emsm_pkg::CMD_SAMPLE |-> !out_valid)
    else $error("sample accepted over a pending result");

  // reset drops any pending result
  a_out_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // config port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind encoder_mt_speed_meter emsm_checker u_emsm_checker (.*);

`default_nettype wire

@@ tb/encoder_mt_speed_meter_tb.sv @@
`default_nettype none

module encoder_mt_speed_meter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = 4;
  localparam int HDEPTH = 8;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    int          msum;
    logic [31:0] fabs;
    logic [31:0] labs;
    bit          edge_mark;
    int          dir;
    logic [15:0] period;
  } slot_t;

  typedef struct {
    emsm_pkg::in_word_t w;
    bit       known;
    int       rpm;
    bit       had;
  } row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  emsm_pkg::in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  emsm_pkg::out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [emsm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  encoder_mt_speed_meter u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // meter model state
  logic [19:0] m_ppr;
  logic [31:0] m_scale;
  logic [2:0]  m_active;
  logic [3:0]  m_invert;
  int          win_cnt[NCH];
  logic [15:0] first_t[NCH];
  logic [15:0] last_t[NCH];
  int          prev_dir[NCH];
  bit          seen[NCH];
  logic [15:0] last_per[NCH];
  logic [15:0] ovf_cnt[NCH];
  logic [31:0] prev_abs[NCH];
  slot_t       ring[NCH][HDEPTH];
  int          wr_idx[NCH];
  int          fill[NCH];

  emsm_pkg::out_word_t rpm_queue[$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  longint    cycles = 0;

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int speed(longint counts, longint ticks);
    longint num, den;
    if (m_ppr == 0) return 0;
    num = counts * longint'({32'b0, m_scale});
    den = ticks * longint'({44'b0, m_ppr});
    return sat32(num / den);
  endfunction

  function automatic int decay(int dir, logic [31:0] now_abs, logic [31:0] from_abs,
                               logic [15:0] per);
    logic [31:0] since, p, eff;
    since = now_abs - from_abs;
    p = (per == 0) ? 32'd1 : {16'b0, per};
    eff = (since > p) ? since : p;
    return speed(dir, longint'({32'b0, eff}));
  endfunction

  function automatic logic [31:0] abs_of(int ch, logic [15:0] t);
    return {ovf_cnt[ch], t};
  endfunction

  function automatic void model_reset();
    m_ppr = 20'd1;
    m_scale = 32'd1;
    m_active = 3'd4;
    m_invert = 4'd0;
    for (int c = 0; c < NCH; c++) begin
      win_cnt[c] = 0; first_t[c] = 0; last_t[c] = 0; prev_dir[c] = 0;
      seen[c] = 0; last_per[c] = 0; ovf_cnt[c] = 0; prev_abs[c] = 0;
      wr_idx[c] = 0; fill[c] = 0;
    end
  endfunction

  function automatic void model_config(logic [emsm_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    case (idx)
      emsm_pkg::REG_EDGES_PER_REV:   m_ppr = val[19:0];
      emsm_pkg::REG_RPM_SCALE:       m_scale = val;
      emsm_pkg::REG_ACTIVE_CHANNELS: m_active = val[2:0];
      emsm_pkg::REG_DIRECTION_INV:   m_invert = val[3:0];
      default: ;
    endcase
  endfunction

  function automatic int sample_rpm(int ch, logic [15:0] now);
    int m, single, res, k, w, r, wdir;
    bit had, any;
    logic [15:0] per, wper;
    logic [31:0] now_abs, d, wf, wl, dt;
    longint am, sum;
    m = win_cnt[ch];
    had = seen[ch];
    per = last_per[ch];
    now_abs = abs_of(ch, now);
    am = (m < 0) ? -longint'(m) : longint'(m);
    single = 0;
    win_cnt[ch] = 0;
    seen[ch] = 0;
    if (am >= 2) begin
      d = {16'b0, last_t[ch] - first_t[ch]};
      if (d == 0) d = 32'd65536;
      single = speed(m, longint'({32'b0, d}));
    end else if (am == 1) begin
      if (per == 0) begin
        d = now_abs - prev_abs[ch];
        if (d == 0) d = 32'd1;
        single = speed(m, longint'({32'b0, d}));
      end else begin
        single = speed(m, longint'({48'b0, per}));
      end
    end else if (prev_dir[ch] != 0) begin
      single = decay(prev_dir[ch], now_abs, prev_abs[ch], per);
    end
    if (am >= emsm_pkg::K_FAST_LIMIT) k = 1;
    else if (am >= 2) k = emsm_pkg::K_MID;
    else k = HDEPTH;
    w = wr_idx[ch];
    ring[ch][w].msum = m;
    ring[ch][w].fabs = had ? abs_of(ch, first_t[ch]) : 32'd0;
    ring[ch][w].labs = had ? abs_of(ch, last_t[ch]) : 32'd0;
    ring[ch][w].edge_mark = had;
    ring[ch][w].dir = prev_dir[ch];
    ring[ch][w].period = per;
    wr_idx[ch] = (w + 1) % HDEPTH;
    if (fill[ch] < HDEPTH) fill[ch]++;
    if (k > fill[ch]) k = fill[ch];
    res = single;
    if (k >= 2) begin
      sum = 0; wf = 0; wl = 0; any = 0; wdir = 0; wper = 0;
      for (int i = 0; i < k; i++) begin
        r = (w + HDEPTH - i) % HDEPTH;
        sum += ring[ch][r].msum;
        if (ring[ch][r].edge_mark) begin
          if (!any) begin
            wl = ring[ch][r].labs;
            wdir = ring[ch][r].dir;
            wper = ring[ch][r].period;
            any = 1;
          end
          wf = ring[ch][r].fabs;
        end
      end
      sum = sat32(sum);
      if (any && sum != 0) begin
        dt = wl - wf;
        if (dt == 0) dt = 32'd1;
        res = speed(sum, longint'({32'b0, dt}));
      end else if (sum == 0 && wdir != 0) begin
        res = decay(wdir, now_abs, wl, wper);
      end
    end
    return res;
  endfunction

  // advance the model by one accepted word; queue the result it causes
  function automatic void model_step(emsm_pkg::in_word_t w);
    int ch, act, dir;
    bit live;
    emsm_pkg::out_word_t o;
    ch = w.channel;
    act = (m_active < NCH) ? m_active : NCH;
    live = ch < act;
    case (w.command)
      emsm_pkg::CMD_FALL, emsm_pkg::CMD_RISE: if (live) begin
        dir = (w.phase_b != (w.command == emsm_pkg::CMD_RISE)) ? 1 : -1;
        if (m_invert[ch]) dir = -dir;
        win_cnt[ch] += dir;
        if (!seen[ch]) begin
          first_t[ch] = w.timer_now;
          seen[ch] = 1;
        end
        last_t[ch] = w.timer_now;
        prev_abs[ch] = abs_of(ch, w.timer_now);
        prev_dir[ch] = dir;
        if (w.command == emsm_pkg::CMD_RISE) last_per[ch] = w.capture_period;
      end
      emsm_pkg::CMD_OVF: if (live) ovf_cnt[ch] = ovf_cnt[ch] + 16'd1;
      default: begin
        o.out_channel = w.channel;
        o.saw_edge = live ? seen[ch] : 1'b0;
        o.rpm = live ? sample_rpm(ch, w.timer_now) : 32'sd0;
        rpm_queue.push_back(o);
      end
    endcase
  endfunction

  task automatic send_word(emsm_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    model_step(w);
  endtask

  task automatic write_reg(logic [emsm_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    model_config(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (rpm_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic emsm_pkg::in_word_t mk(emsm_pkg::cmd_t c, int ch, bit b, int t, int cap);
    emsm_pkg::in_word_t w;
    w.command = c;
    w.channel = ch[1:0];
    w.phase_b = b;
    w.timer_now = t[15:0];
    w.capture_period = cap[15:0];
    return w;
  endfunction

  task automatic run_random(int n);
    int sent, ch, ne, t, nt;
    bit pos, b;
    emsm_pkg::cmd_t c;
    sent = 0;
    while (sent < n) begin
      ch = $urandom_range(NCH - 1);
      if ($urandom_range(9) < 2) begin
        send_word(mk(emsm_pkg::cmd_t'($urandom_range(3)), int'($urandom_range(3)),
                     1'($urandom_range(1)), int'($urandom), int'($urandom)));
        sent++;
      end else begin
        t = $urandom_range(65535);
        ne = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
        pos = $urandom_range(1);
        for (int i = 0; i < ne; i++) begin
          nt = (t + $urandom_range(1, 4000)) % 65536;
          if (nt < t) begin
            send_word(mk(emsm_pkg::CMD_OVF, ch, $urandom_range(1), $urandom, $urandom));
            sent++;
          end
          t = nt;
          c = $urandom_range(1) ? emsm_pkg::CMD_RISE : emsm_pkg::CMD_FALL;
          b = (c == emsm_pkg::CMD_RISE) ? !pos : pos;
          if ($urandom_range(9) == 0) b = !b;
          send_word(mk(c, ch, b, t, ($urandom_range(7) == 0) ? 0 : $urandom));
          sent++;
        end
        t = (t + $urandom_range(0, 4000)) % 65536;
        send_word(mk(emsm_pkg::CMD_SAMPLE, ch, $urandom_range(1), t, $urandom));
        sent++;
      end
    end
  endtask

  // receiver side: stall at random per phase
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    emsm_pkg::out_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (rpm_queue.size() == 0) begin
        report("unexpected word", out_data.rpm, 0);
      end else begin
        e = rpm_queue.pop_front();
        if (out_data.out_channel !== e.out_channel)
          report("out_channel", out_data.out_channel, e.out_channel);
        if (out_data.rpm !== e.rpm) report("rpm", out_data.rpm, e.rpm);
        if (out_data.saw_edge !== e.saw_edge) report("saw_edge", out_data.saw_edge, e.saw_edge);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  row_t rows[$];
  logic [31:0] cfg_sets[6][4] = '{
    '{32'd0, 32'd1000, 32'd4, 32'd0},
    '{32'd1048575, 32'hffffffff, 32'd4, 32'd15},
    '{32'd4, 32'd60000000, 32'd2, 32'd5},
    '{32'd1, 32'hffffffff, 32'd7, 32'd10},
    '{32'd1024, 32'd1, 32'd1, 32'd1},
    '{32'd2000, 32'd120000000, 32'd0, 32'd3}
  };

  initial begin
    emsm_pkg::out_word_t got;
    model_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // known rows: fresh channels sample to zero
    rows.push_back('{mk(emsm_pkg::CMD_SAMPLE, 0, 0, 0, 0), 1, 0, 0});
    rows.push_back('{mk(emsm_pkg::CMD_SAMPLE, 3, 1, 65535, 65535), 1, 0, 0});
    rows.push_back('{mk(emsm_pkg::CMD_FALL, 1, 1, 100, 0), 0, 0, 0});
    rows.push_back('{mk(emsm_pkg::CMD_FALL, 1, 1, 200, 0), 0, 0, 0});
    rows.push_back('{mk(emsm_pkg::CMD_RISE, 1, 0, 300, 0), 0, 0, 0});
    rows.push_back('{mk(emsm_pkg::CMD_SAMPLE, 1, 0, 400, 0), 0, 0, 0});
    rows.push_back('{mk(emsm_pkg::CMD_SAMPLE, 1, 0, 900, 0), 0, 0, 0});
    rows.push_back('{mk(emsm_pkg::CMD_OVF, 2, 0, 0, 0), 0, 0, 0});
    rows.push_back('{mk(emsm_pkg::CMD_RISE, 2, 1, 65535, 65535), 0, 0, 0});
    rows.push_back('{mk(emsm_pkg::CMD_SAMPLE, 2, 0, 65535, 0), 0, 0, 0});
    rows.push_back('{mk(emsm_pkg::CMD_SAMPLE, 2, 1, 0, 0), 0, 0, 0});
    rows.push_back('{mk(emsm_pkg::CMD_FALL, 3, 0, 0, 0), 0, 0, 0});
    rows.push_back('{mk(emsm_pkg::CMD_FALL, 3, 0, 0, 0), 0, 0, 0});
    rows.push_back('{mk(emsm_pkg::CMD_SAMPLE, 3, 0, 0, 0), 0, 0, 0});
    rows.push_back('{mk(emsm_pkg::CMD_RISE, 0, 0, 10, 0), 0, 0, 0});
    rows.push_back('{mk(emsm_pkg::CMD_SAMPLE, 0, 0, 10, 0), 0, 0, 0});
    rows.push_back('{mk(emsm_pkg::CMD_SAMPLE, 0, 0, 50, 0), 0, 0, 0});
    for (int i = 0; i < 7; i++)
      rows.push_back('{mk(emsm_pkg::CMD_FALL, 0, 1, 1000 + 7 * i, 0), 0, 0, 0});
    rows.push_back('{mk(emsm_pkg::CMD_SAMPLE, 0, 1, 2000, 0), 0, 0, 0});

    foreach (rows[i]) begin
      send_word(rows[i].w);
      if (rows[i].known) begin
        got = rpm_queue[$];
        if (got.rpm != rows[i].rpm) report("table rpm", got.rpm, rows[i].rpm);
        if (got.saw_edge != rows[i].had) report("table saw_edge", got.saw_edge, rows[i].had);
      end
    end
    drain();

    for (int p = 0; p < 6; p++) begin
      for (int r = 0; r < 4; r++) write_reg(r[emsm_pkg::CFG_IDX_W-1:0], cfg_sets[p][r]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      run_random(185);
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ encoder_mt_speed_meter.f @@
design/emsm_pkg.sv
design/encoder_mt_speed_meter.sv
design/emsm_checker.sv
tb/encoder_mt_speed_meter_tb.sv
